// ===== design/src_pkg.sv =====
// Package: shared constants, tables and types of the sphere region classifier.
package src_pkg;

  // Default sizes
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int ANGLE_BITS_DEF   = 16;

  // Longitude datapath
  localparam int CORDIC_STEPS = 30;
  localparam int ACC_W        = 32;
  localparam int SHIFT_W      = 5;
  localparam int NORM_MSB     = 29;  // normalize until the larger magnitude reaches 2^29

  // Latitude datapath: |v|^2 fits in 2*32+2 bits at the widest sample
  localparam int N2_MAX_W = 66;
  localparam int PROD_W   = N2_MAX_W + ACC_W;

  // Result
  localparam int REGION_W    = 7;
  localparam int COUNT_W     = 6;
  localparam int OUT_TDATA_W = 8;
  localparam logic [REGION_W-1:0] REGION_LAST = REGION_W'(99);

  // sin^2 of the collar boundaries, Q0.32
  localparam logic [ACC_W-1:0] SIN2_TEMPERATE = 32'd4124838082;  // 78.52 deg
  localparam logic [ACC_W-1:0] SIN2_TROPIC    = 32'd1985720565;  // 42.84 deg

  // Angle landmarks, in fractions of a turn
  localparam logic [ACC_W-1:0] QUARTER_TURN  = 32'h4000_0000;
  localparam logic [ACC_W-1:0] HALF_TURN     = 32'h8000_0000;
  localparam logic [ACC_W-1:0] THREE_QUARTER = 32'hC000_0000;
  localparam logic [ACC_W-1:0] TURN_MAX      = 32'hFFFF_FFFF;

  // atan(2^-i) in turns, Q0.32
  localparam logic [ACC_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1
  };

  // Collars from north to south
  typedef enum logic [2:0] {
    COLLAR_NPOLE,
    COLLAR_NTEMP,
    COLLAR_NTROP,
    COLLAR_STROP,
    COLLAR_STEMP,
    COLLAR_SPOLE
  } collar_e;

  // Side information that rides along the CORDIC chain
  typedef struct packed {
    collar_e collar;
    logic    y_zero;
    logic    y_neg;
    logic    x_neg;
  } side_t;

endpackage

// ===== design/src_front.sv =====
// Front end: squares, latitude collar test, normalization and pre-rotation.
module src_front
  import src_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CW           = 35
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic signed [SAMPLE_WIDTH-1:0] x_axis_i,
  input  logic signed [SAMPLE_WIDTH-1:0] y_axis_i,
  input  logic signed [SAMPLE_WIDTH-1:0] z_axis_i,
  output logic                           valid_o,
  output logic signed [CW-1:0]           u_o,
  output logic signed [CW-1:0]           v_o,
  output logic [ACC_W-1:0]               acc_o,
  output side_t                          side_o
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int SQ_W = 2 * SW;
  localparam int N2W  = 2 * SW + 2;
  localparam int TB_W = $clog2(SW);

  // ---------------- stage 1: squares, magnitudes, shift amount
  logic signed [SQ_W-1:0] sqx, sqy, sqz;
  logic [SW-1:0]          ax, ay, mag_or;
  logic [TB_W-1:0]        top_bit;
  logic [SHIFT_W-1:0]     shamt;

  assign sqx    = x_axis_i * x_axis_i;
  assign sqy    = y_axis_i * y_axis_i;
  assign sqz    = z_axis_i * z_axis_i;
  assign ax     = x_axis_i[SW-1] ? SW'(-x_axis_i) : SW'(x_axis_i);
  assign ay     = y_axis_i[SW-1] ? SW'(-y_axis_i) : SW'(y_axis_i);
  assign mag_or = ax | ay;

  // highest set bit of the larger magnitude
  always_comb begin
    top_bit = '0;
    for (int b = 0; b < SW; b++) begin
      if (mag_or[b]) begin
        top_bit = TB_W'(b);
      end
    end
    shamt = (int'(top_bit) >= NORM_MSB) ? '0 : SHIFT_W'(NORM_MSB - int'(top_bit));
  end

  logic                   s1_valid_q;
  logic [SQ_W-1:0]        s1_sqx_q, s1_sqy_q, s1_sqz_q;
  logic signed [SW-1:0]   s1_x_q, s1_y_q;
  logic                   s1_north_q;
  logic [SHIFT_W-1:0]     s1_shamt_q;

  // ---------------- stage 2: |v|^2, pre-rotation
  logic [N2W-1:0]         n2;
  logic signed [CW-1:0]   xs, ys, u0, v0;
  logic [ACC_W-1:0]       acc0;
  side_t                  side2;

  assign n2 = N2W'(s1_sqx_q) + N2W'(s1_sqy_q) + N2W'(s1_sqz_q);
  assign xs = CW'(s1_x_q) <<< s1_shamt_q;
  assign ys = CW'(s1_y_q) <<< s1_shamt_q;

  // rotate into the right half plane of (-x, -y)
  always_comb begin
    if (xs > 0) begin
      u0   = xs;
      v0   = ys;
      acc0 = HALF_TURN;
    end else begin
      u0   = -xs;
      v0   = -ys;
      acc0 = '0;
    end
    side2.collar = COLLAR_NPOLE;
    side2.y_zero = (s1_y_q == '0);
    side2.y_neg  = s1_y_q[SW-1];
    side2.x_neg  = s1_x_q[SW-1];
  end

  logic                   s2_valid_q;
  logic [N2W-1:0]         s2_n2_q;
  logic [SQ_W-1:0]        s2_z2_q;
  logic                   s2_north_q;
  logic signed [CW-1:0]   s2_u_q, s2_v_q;
  logic [ACC_W-1:0]       s2_acc_q;
  side_t                  s2_side_q;

  // ---------------- stage 3: sin^2 * |v|^2 as partial products
  logic [N2_MAX_W-1:0]       n2_ext;
  logic [2*ACC_W-1:0]        p_tl, p_rl;
  logic [N2_MAX_W-1:0]       p_th, p_rh;

  assign n2_ext = N2_MAX_W'(s2_n2_q);
  assign p_tl   = n2_ext[ACC_W-1:0] * SIN2_TEMPERATE;
  assign p_th   = n2_ext[N2_MAX_W-1:ACC_W] * SIN2_TEMPERATE;
  assign p_rl   = n2_ext[ACC_W-1:0] * SIN2_TROPIC;
  assign p_rh   = n2_ext[N2_MAX_W-1:ACC_W] * SIN2_TROPIC;

  logic                   s3_valid_q;
  logic [2*ACC_W-1:0]     s3_p_tl_q, s3_p_rl_q;
  logic [N2_MAX_W-1:0]    s3_p_th_q, s3_p_rh_q;
  logic [SQ_W-1:0]        s3_z2_q;
  logic                   s3_north_q;
  logic signed [CW-1:0]   s3_u_q, s3_v_q;
  logic [ACC_W-1:0]       s3_acc_q;
  side_t                  s3_side_q;

  // ---------------- stage 4: compare z^2 * 2^32 against both products
  logic [PROD_W-1:0] z2_scaled, b_temp, b_trop;
  logic              ge_temp, le_temp, ge_trop, le_trop;
  side_t             side4;

  assign z2_scaled = PROD_W'({s3_z2_q, ACC_W'(0)});
  assign b_temp    = PROD_W'({s3_p_th_q, ACC_W'(0)}) + PROD_W'(s3_p_tl_q);
  assign b_trop    = PROD_W'({s3_p_rh_q, ACC_W'(0)}) + PROD_W'(s3_p_rl_q);
  assign ge_temp   = (z2_scaled >= b_temp);
  assign le_temp   = (z2_scaled <= b_temp);
  assign ge_trop   = (z2_scaled >= b_trop);
  assign le_trop   = (z2_scaled <= b_trop);

  // boundary samples belong to the collar north of them
  always_comb begin
    side4 = s3_side_q;
    priority if (s3_north_q && ge_temp) begin
      side4.collar = COLLAR_NPOLE;
    end else if (s3_north_q && ge_trop) begin
      side4.collar = COLLAR_NTEMP;
    end else if (s3_north_q) begin
      side4.collar = COLLAR_NTROP;
    end else if (le_trop) begin
      side4.collar = COLLAR_STROP;
    end else if (le_temp) begin
      side4.collar = COLLAR_STEMP;
    end else begin
      side4.collar = COLLAR_SPOLE;
    end
  end

  logic                   s4_valid_q;
  logic signed [CW-1:0]   s4_u_q, s4_v_q;
  logic [ACC_W-1:0]       s4_acc_q;
  side_t                  s4_side_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sqx_q   <= SQ_W'(sqx);
      s1_sqy_q   <= SQ_W'(sqy);
      s1_sqz_q   <= SQ_W'(sqz);
      s1_x_q     <= x_axis_i;
      s1_y_q     <= y_axis_i;
      s1_north_q <= ~z_axis_i[SW-1];
      s1_shamt_q <= shamt;

      s2_n2_q    <= n2;
      s2_z2_q    <= s1_sqz_q;
      s2_north_q <= s1_north_q;
      s2_u_q     <= u0;
      s2_v_q     <= v0;
      s2_acc_q   <= acc0;
      s2_side_q  <= side2;

      s3_p_tl_q  <= p_tl;
      s3_p_th_q  <= p_th;
      s3_p_rl_q  <= p_rl;
      s3_p_rh_q  <= p_rh;
      s3_z2_q    <= s2_z2_q;
      s3_north_q <= s2_north_q;
      s3_u_q     <= s2_u_q;
      s3_v_q     <= s2_v_q;
      s3_acc_q   <= s2_acc_q;
      s3_side_q  <= s2_side_q;

      s4_u_q     <= s3_u_q;
      s4_v_q     <= s3_v_q;
      s4_acc_q   <= s3_acc_q;
      s4_side_q  <= side4;
    end
  end

  assign valid_o = s4_valid_q;
  assign u_o     = s4_u_q;
  assign v_o     = s4_v_q;
  assign acc_o   = s4_acc_q;
  assign side_o  = s4_side_q;

endmodule

// ===== design/src_cell.sv =====
// One CORDIC vectoring cell: a single micro-rotation, registered.
module src_cell
  import src_pkg::*;
#(
  parameter int CW   = 35,
  parameter int STEP = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] u_i,
  input  logic signed [CW-1:0] v_i,
  input  logic [ACC_W-1:0]     acc_i,
  input  side_t                side_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] u_o,
  output logic signed [CW-1:0] v_o,
  output logic [ACC_W-1:0]     acc_o,
  output side_t                side_o
);

  localparam logic [ACC_W-1:0] ATAN = ATAN_TURNS[STEP];

  logic signed [CW-1:0] us, vs, u_d, v_d, u_q, v_q;
  logic [ACC_W-1:0]     acc_d, acc_q;
  logic                 valid_q;
  side_t                side_q;

  assign us = u_i >>> STEP;
  assign vs = v_i >>> STEP;

  // rotate toward v = 0, accumulating the angle
  always_comb begin
    if (!v_i[CW-1]) begin
      u_d   = u_i + vs;
      v_d   = v_i - us;
      acc_d = acc_i + ATAN;
    end else begin
      u_d   = u_i - vs;
      v_d   = v_i + us;
      acc_d = acc_i - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q    <= u_d;
      v_q    <= v_d;
      acc_q  <= acc_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign u_o     = u_q;
  assign v_o     = v_q;
  assign acc_o   = acc_q;
  assign side_o  = side_q;

endmodule

// ===== design/src_back.sv =====
// Back end: longitude guards, subregion and region number, output register.
module src_back
  import src_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [ACC_W-1:0]    acc_i,
  input  side_t               side_i,
  output logic                valid_o,
  output logic [REGION_W-1:0] region_o
);

  localparam int AB    = ANGLE_BITS;
  localparam int MUL_W = AB + COUNT_W;

  localparam int TEMP_COUNT = 15;
  localparam int TROP_COUNT = 34;
  localparam int BASE_NTEMP = 1;
  localparam int BASE_NTROP = BASE_NTEMP + TEMP_COUNT;
  localparam int BASE_STROP = BASE_NTROP + TROP_COUNT;
  localparam int BASE_STEMP = BASE_STROP + TROP_COUNT;
  localparam int BASE_SPOLE = BASE_STEMP + TEMP_COUNT;

  function automatic logic [COUNT_W-1:0] collar_count(collar_e c);
    logic [COUNT_W-1:0] n;
    unique case (c)
      COLLAR_NTEMP, COLLAR_STEMP: n = COUNT_W'(TEMP_COUNT);
      COLLAR_NTROP, COLLAR_STROP: n = COUNT_W'(TROP_COUNT);
      COLLAR_NPOLE, COLLAR_SPOLE: n = COUNT_W'(1);
      default:                    n = COUNT_W'(1);
    endcase
    return n;
  endfunction

  function automatic logic [REGION_W-1:0] collar_base(collar_e c);
    logic [REGION_W-1:0] b;
    unique case (c)
      COLLAR_NPOLE: b = '0;
      COLLAR_NTEMP: b = REGION_W'(BASE_NTEMP);
      COLLAR_NTROP: b = REGION_W'(BASE_NTROP);
      COLLAR_STROP: b = REGION_W'(BASE_STROP);
      COLLAR_STEMP: b = REGION_W'(BASE_STEMP);
      COLLAR_SPOLE: b = REGION_W'(BASE_SPOLE);
      default:      b = '0;
    endcase
    return b;
  endfunction

  logic [ACC_W-1:0]    acc_fix;
  logic [AB-1:0]       ang;
  logic [COUNT_W-1:0]  n, sub_raw, sub;
  logic [MUL_W-1:0]    prod;
  logic [REGION_W-1:0] region_d, region_q;
  logic                valid_q;

  // negative x axis is a full turn; keep the angle in the half that y selects
  always_comb begin
    priority if (side_i.y_zero) begin
      acc_fix = side_i.x_neg ? TURN_MAX : HALF_TURN;
    end else if (side_i.y_neg && (acc_i >= HALF_TURN)) begin
      acc_fix = (acc_i >= THREE_QUARTER) ? '0 : (HALF_TURN - ACC_W'(1));
    end else if (!side_i.y_neg && (acc_i < HALF_TURN)) begin
      acc_fix = (acc_i < QUARTER_TURN) ? TURN_MAX : HALF_TURN;
    end else begin
      acc_fix = acc_i;
    end
  end

  // subregion = floor(n * angle), clamped to n-1
  assign ang     = acc_fix[ACC_W-1 -: AB];
  assign n       = collar_count(side_i.collar);
  assign prod    = MUL_W'(n) * MUL_W'(ang);
  assign sub_raw = prod[MUL_W-1:AB];

  always_comb begin
    if (n > COUNT_W'(1)) begin
      sub = (sub_raw > (n - COUNT_W'(1))) ? (n - COUNT_W'(1)) : sub_raw;
    end else begin
      sub = '0;
    end
    region_d = collar_base(side_i.collar) + REGION_W'(sub);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      region_q <= region_d;
    end
  end

  assign valid_o  = valid_q;
  assign region_o = region_q;

endmodule

// ===== design/sphere_region_classifier.sv =====
// Top level of the sphere region classifier: input skid, front end, CORDIC chain, back end.
//
// Usage:
//   Slave stream s_*: one item per transfer, s_tdata_i holds x_axis, y_axis, z_axis
//   (SAMPLE_WIDTH bits each, two's complement, x in the lowest bits).
//   Master stream m_*: one item per input item, m_tdata_o bits [6:0] hold the region
//   index 0..99 (0 north pole, 99 south pole), bit 7 is zero.
//   Pipeline: 35 register stages (4 front-end stages, 30 CORDIC cells, 1 output
//   stage), all moving together.
//   Throughput: one item per cycle while the output is taken; the 30-cell CORDIC
//   chain and the front-end multiplier stages each take a new item every cycle
//   while the pipeline is not held.
//   Stall: when the output item is not taken, the whole pipeline holds; the input
//   side still takes one more item into a skid register and then drops tready until
//   the output moves again.
//   Reset: rst_ni clears all valid bits and the skid valid bit; the block is ready
//   in the first cycle after reset, with no clearing pass.
module sphere_region_classifier
  import src_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int ANGLE_BITS   = ANGLE_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_tvalid_i,
  output logic                                      s_tready_o,
  // x_axis, y_axis, z_axis from the lowest bit up, zero padded to bytes
  input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata_i,
  output logic                                      m_tvalid_o,
  input  logic                                      m_tready_i,
  // region_index [6:0], zero pad [7]
  output logic [OUT_TDATA_W-1:0]                    m_tdata_o
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int IN_W = 3 * SW;
  localparam int CW   = ((SW > 31) ? SW : 31) + 4;

  // pipeline moves whenever the output register is free or being read
  logic en;
  assign en = m_tready_i | ~m_tvalid_o;

  // ---------------- input skid register
  logic            skid_vld_q, skid_vld_d;
  logic [IN_W-1:0] skid_q;
  logic            in_acc, entry_valid;
  logic [IN_W-1:0] entry_data;

  assign s_tready_o  = ~skid_vld_q;
  assign in_acc      = s_tvalid_i & s_tready_o;
  assign entry_valid = skid_vld_q | in_acc;
  assign entry_data  = skid_vld_q ? skid_q : s_tdata_i[IN_W-1:0];
  assign skid_vld_d  = en ? 1'b0 : (skid_vld_q | in_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else begin
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !en) begin
      skid_q <= s_tdata_i[IN_W-1:0];
    end
  end

  // ---------------- front end
  logic                 valid_c [CORDIC_STEPS+1];
  logic signed [CW-1:0] u_c     [CORDIC_STEPS+1];
  logic signed [CW-1:0] v_c     [CORDIC_STEPS+1];
  logic [ACC_W-1:0]     acc_c   [CORDIC_STEPS+1];
  side_t                side_c  [CORDIC_STEPS+1];

  src_front #(
    .SAMPLE_WIDTH(SW),
    .CW          (CW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (entry_valid),
    .x_axis_i(signed'(entry_data[SW-1:0])),
    .y_axis_i(signed'(entry_data[2*SW-1:SW])),
    .z_axis_i(signed'(entry_data[3*SW-1:2*SW])),
    .valid_o (valid_c[0]),
    .u_o     (u_c[0]),
    .v_o     (v_c[0]),
    .acc_o   (acc_c[0]),
    .side_o  (side_c[0])
  );

  // ---------------- CORDIC chain
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
    src_cell #(
      .CW  (CW),
      .STEP(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(valid_c[g]),
      .u_i    (u_c[g]),
      .v_i    (v_c[g]),
      .acc_i  (acc_c[g]),
      .side_i (side_c[g]),
      .valid_o(valid_c[g+1]),
      .u_o    (u_c[g+1]),
      .v_o    (v_c[g+1]),
      .acc_o  (acc_c[g+1]),
      .side_o (side_c[g+1])
    );
  end

  // ---------------- back end and output register
  logic [REGION_W-1:0] region;

  src_back #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_c[CORDIC_STEPS]),
    .acc_i   (acc_c[CORDIC_STEPS]),
    .side_i  (side_c[CORDIC_STEPS]),
    .valid_o (m_tvalid_o),
    .region_o(region)
  );

  assign m_tdata_o = OUT_TDATA_W'(region);

endmodule

// ===== design/src_checker.sv =====
// Port-level checker for the sphere region classifier, bound to the top level.
module src_checker
  import src_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_tready_i,
  input logic                   m_tvalid_i,
  input logic                   m_tready_i,
  input logic [OUT_TDATA_W-1:0] m_tdata_i
);

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i))
    else $error("output item changed while stalled");

  // region index in range, pad bit clear
  a_region_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i |-> (m_tdata_i[REGION_W-1:0] <= REGION_LAST) && !m_tdata_i[OUT_TDATA_W-1])
    else $error("region index out of range");

  // input side only backs up after an output stall
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_i |-> $past(m_tvalid_i && !m_tready_i))
    else $error("input not ready without an output stall");

  // skid item drains as soon as the output moves
  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_i && m_tready_i |=> s_tready_i)
    else $error("skid item did not drain");

endmodule

bind sphere_region_classifier src_checker u_src_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_tready_i(s_tready_o),
  .m_tvalid_i(m_tvalid_o),
  .m_tready_i(m_tready_i),
  .m_tdata_i (m_tdata_o)
);
